/* src/pdlf_pkg.sv */
// Shared constants and types for the PD line-follow steering block.
`timescale 1ns / 1ps
package pdlf_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int SETPOINT_BITS   = 10;
	localparam int GAIN_BITS       = 16;
	localparam int THR_BITS        = 16;
	localparam int SPEED_BITS      = 7;
	localparam int OUT_BITS        = 8;
	localparam int MIX_BITS        = 10;
	localparam int MAG_BITS        = 17;
	localparam int SCALED_BITS     = 18;
	localparam int FRAC_BITS       = 8;
	localparam int NEG_SCALE       = 358;
	localparam int ADDR_BITS       = 5;
	localparam int DATA_BITS       = 32;

	localparam logic [SETPOINT_BITS-1:0] SETPOINT_RST  = 10'd512;
	localparam logic [GAIN_BITS-1:0]     KP_GAIN_RST   = 16'd256;
	localparam logic [GAIN_BITS-1:0]     KD_GAIN_RST   = 16'd0;
	localparam logic [THR_BITS-1:0]      THRESHOLD_RST = 16'd7287;
	localparam logic [SPEED_BITS-1:0]    BASE_RST      = 7'd10;
	localparam logic [SPEED_BITS-1:0]    MAX_RST       = 7'd85;

	typedef enum logic [2:0] {
		REG_SETPOINT  = 3'd0,
		REG_KP_GAIN   = 3'd1,
		REG_KD_GAIN   = 3'd2,
		REG_THRESHOLD = 3'd3,
		REG_BASE      = 3'd4,
		REG_MAX       = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROP,
		ST_DERIV,
		ST_MAG,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage

/* src/pd_line_follow_steering_top.sv */
// Top level of the PD line-follow steering block.
`timescale 1ns / 1ps
// Usage:
//   s_* stream carries one light sample per beat; m_* stream returns one beat with
//   the left and right motor speeds for every sample, in order.
//   The APB port writes and reads setpoint, gains, turn threshold, base and max speed;
//   write it only while no sample is in flight.
//   Each sample runs through PROP, DERIV, MAG, SCALE and DONE before m_tvalid: one shared
//   signed multiplier forms kp*error, then kd*delta, then the 358/256 scale of a negative
//   pd in PROP, DERIV and SCALE, with the magnitude step in MAG and steering in DONE.
//   s_tready is high only while the sequencer is idle, so no new sample is taken
//   until the last one has passed DONE.
//   The result sits in an output register; the next sample is accepted while it
//   waits. A stalled m_tready holds the sequencer at its last step until the
//   register frees.
//   Reset loads the register defaults, clears the previous error and empties the
//   output register.
module pd_line_follow_steering_top
	import pdlf_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // light_sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*OUT_BITS-1:0]               m_tdata,   // left_speed, right_speed
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ADDR_BITS-1:0]                paddr,
	input  logic [DATA_BITS-1:0]                pwdata,
	output logic [DATA_BITS-1:0]                prdata,
	output logic                                pready
);

	localparam int EW = ((SAMPLE_BITS > SETPOINT_BITS) ? SAMPLE_BITS : SETPOINT_BITS) + 1;
	localparam int DW = EW + 1;
	localparam int MA = (DW > MAG_BITS + 1) ? DW : MAG_BITS + 1;
	localparam int MB = GAIN_BITS + 1;
	localparam int PW = MA + MB;
	localparam int AW = EW + GAIN_BITS + 2;

	state_t state_q, state_n;

	logic [SETPOINT_BITS-1:0]    setpoint_q;
	logic signed [GAIN_BITS-1:0] kp_gain_q;
	logic signed [GAIN_BITS-1:0] kd_gain_q;
	logic [THR_BITS-1:0]         thr_q;
	logic [SPEED_BITS-1:0]       base_q;
	logic [SPEED_BITS-1:0]       max_q;

	logic signed [EW-1:0]        last_err_q;
	logic signed [EW-1:0]        err_q;
	logic signed [DW-1:0]        diff_q;
	logic signed [AW-1:0]        acc_q;
	logic [SCALED_BITS-1:0]      mag_q;
	logic                        neg_q;
	logic                        m_tvalid_q;
	logic [2*OUT_BITS-1:0]       m_tdata_q;

	logic signed [EW-1:0]        err_n;
	logic signed [DW-1:0]        diff_n;
	logic signed [MA-1:0]        mul_a;
	logic signed [MB-1:0]        mul_b;
	logic signed [PW-1:0]        mul_p;
	logic signed [AW-1:0]        prod_w;
	logic signed [AW-1:0]        abs_w;
	logic [MAG_BITS-1:0]         mag_w;
	logic                        cfg_wr;
	logic                        in_acc;
	logic                        out_free;
	logic                        spin;
	logic signed [MIX_BITS-1:0]  p_w;
	logic signed [MIX_BITS-1:0]  base_w;
	logic signed [MIX_BITS-1:0]  left_w;
	logic signed [MIX_BITS-1:0]  right_w;
	logic signed [OUT_BITS-1:0]  left_sat;
	logic signed [OUT_BITS-1:0]  right_sat;

	function automatic logic signed [OUT_BITS-1:0] sat_speed(
		input logic signed [MIX_BITS-1:0] v,
		input logic [SPEED_BITS-1:0]      lim
	);
		logic signed [MIX_BITS-1:0] hi;
		logic signed [MIX_BITS-1:0] lo;
		logic signed [MIX_BITS-1:0] r;
		hi = $signed(MIX_BITS'(lim));
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[OUT_BITS-1:0];
	endfunction

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign in_acc   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			kp_gain_q  <= KP_GAIN_RST;
			kd_gain_q  <= KD_GAIN_RST;
			thr_q      <= THRESHOLD_RST;
			base_q     <= BASE_RST;
			max_q      <= MAX_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
				REG_SETPOINT:  setpoint_q <= pwdata[SETPOINT_BITS-1:0];
				REG_KP_GAIN:   kp_gain_q  <= pwdata[GAIN_BITS-1:0];
				REG_KD_GAIN:   kd_gain_q  <= pwdata[GAIN_BITS-1:0];
				REG_THRESHOLD: thr_q      <= pwdata[THR_BITS-1:0];
				REG_BASE:      base_q     <= pwdata[SPEED_BITS-1:0];
				REG_MAX:       max_q      <= pwdata[SPEED_BITS-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
			REG_SETPOINT:  prdata = DATA_BITS'(setpoint_q);
			REG_KP_GAIN:   prdata = DATA_BITS'(kp_gain_q);
			REG_KD_GAIN:   prdata = DATA_BITS'(kd_gain_q);
			REG_THRESHOLD: prdata = DATA_BITS'(thr_q);
			REG_BASE:      prdata = DATA_BITS'(base_q);
			REG_MAX:       prdata = DATA_BITS'(max_q);
			default:       prdata = '0;
		endcase
	end

	// error and delta from the new sample
	assign err_n  = $signed(EW'(s_tdata[SAMPLE_BITS-1:0]) - EW'(setpoint_q));
	assign diff_n = DW'(err_n) - DW'(last_err_q);

	// shared multiplier
	assign mul_p  = mul_a * mul_b;
	assign prod_w = mul_p[AW-1:0];

	// magnitude of pd, clamped where the outcome is a spin turn anyway
	assign abs_w = acc_q[AW-1] ? -acc_q : acc_q;
	assign mag_w = (|abs_w[AW-1:MAG_BITS]) ? {MAG_BITS{1'b1}} : abs_w[MAG_BITS-1:0];

	// steering decision
	assign spin   = mag_q >= SCALED_BITS'(thr_q);
	assign base_w = $signed(MIX_BITS'(base_q));
	assign p_w    = neg_q ? -$signed(MIX_BITS'(mag_q[FRAC_BITS+7:FRAC_BITS]))
	                      :  $signed(MIX_BITS'(mag_q[FRAC_BITS+7:FRAC_BITS]));

	always_comb begin
		if (spin && !neg_q) begin
			left_w  = -base_w;
			right_w = base_w;
		end else if (spin) begin
			left_w  = base_w;
			right_w = -base_w;
		end else begin
			left_w  = base_w - p_w;
			right_w = base_w + p_w;
		end
	end

	assign left_sat  = sat_speed(left_w, max_q);
	assign right_sat = sat_speed(right_w, max_q);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_n = ST_PROP;
			ST_PROP:  state_n = ST_DERIV;
			ST_DERIV: state_n = ST_MAG;
			ST_MAG:   state_n = ST_SCALE;
			ST_SCALE: state_n = ST_DONE;
			ST_DONE:  if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_PROP: begin
				mul_a = MA'(err_q);
				mul_b = MB'(kp_gain_q);
			end
			ST_DERIV: begin
				mul_a = MA'(diff_q);
				mul_b = MB'(kd_gain_q);
			end
			ST_SCALE: begin
				mul_a = $signed(MA'(mag_q[MAG_BITS-1:0]));
				mul_b = MB'(NEG_SCALE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_err_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (in_acc) begin
				last_err_q <= err_n;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q  <= err_n;
				diff_q <= diff_n;
			end
			ST_PROP:  acc_q <= prod_w;
			ST_DERIV: acc_q <= acc_q + prod_w;
			ST_MAG: begin
				neg_q <= acc_q[AW-1];
				mag_q <= SCALED_BITS'(mag_w);
			end
			ST_SCALE: if (neg_q) mag_q <= mul_p[FRAC_BITS+SCALED_BITS-1:FRAC_BITS];
			ST_DONE: if (out_free) m_tdata_q <= {right_sat, left_sat};
			default: ;
		endcase
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the PD line-follow steering block.
module tb_top;
	import pdlf_pkg::*;

	localparam int TDATA_BITS  = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 40;
	localparam logic [2:0] IDX_UNMAPPED_LO = 3'd6;
	localparam logic [2:0] IDX_UNMAPPED_HI = 3'd7;

	typedef struct {
		logic signed [OUT_BITS-1:0] left;
		logic signed [OUT_BITS-1:0] right;
	} speeds_t;

	class steer_scoreboard;
		logic [SETPOINT_BITS-1:0]    setpoint;
		logic signed [GAIN_BITS-1:0] kp;
		logic signed [GAIN_BITS-1:0] kd;
		logic [THR_BITS-1:0]         thr;
		logic [SPEED_BITS-1:0]       base;
		logic [SPEED_BITS-1:0]       vmax;
		longint                      prev_err;
		speeds_t                     speed_q[$];
		int                          errors;

		function new();
			setpoint = SETPOINT_RST;
			kp = KP_GAIN_RST;
			kd = KD_GAIN_RST;
			thr = THRESHOLD_RST;
			base = BASE_RST;
			vmax = MAX_RST;
			prev_err = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [DATA_BITS-1:0] val);
			case (idx)
				REG_SETPOINT: setpoint = val[SETPOINT_BITS-1:0];
				REG_KP_GAIN: kp = val[GAIN_BITS-1:0];
				REG_KD_GAIN: kd = val[GAIN_BITS-1:0];
				REG_THRESHOLD: thr = val[THR_BITS-1:0];
				REG_BASE: base = val[SPEED_BITS-1:0];
				REG_MAX: vmax = val[SPEED_BITS-1:0];
				default: ;
			endcase
		endfunction

		function speeds_t predict_speeds(logic [SAMPLE_BITS_DEF-1:0] s);
			longint err;
			longint pd;
			longint p;
			longint left;
			longint right;
			longint bspd;
			longint lim;
			speeds_t r;
			err = longint'(s) - longint'(setpoint);
			pd = longint'(kp) * err + longint'(kd) * (err - prev_err);
			if (pd < 0)
				pd = -(((-pd) * NEG_SCALE) >>> FRAC_BITS);
			bspd = longint'(base);
			lim = longint'(vmax);
			if (pd >= longint'(thr)) begin
				left = -bspd;
				right = bspd;
			end else if (pd <= -longint'(thr)) begin
				left = bspd;
				right = -bspd;
			end else begin
				p = (pd < 0) ? -((-pd) >>> FRAC_BITS) : (pd >>> FRAC_BITS);
				left = bspd - p;
				right = bspd + p;
			end
			if (left > lim)
				left = lim;
			else if (left < -lim)
				left = -lim;
			if (right > lim)
				right = lim;
			else if (right < -lim)
				right = -lim;
			prev_err = err;
			r.left = left[OUT_BITS-1:0];
			r.right = right[OUT_BITS-1:0];
			return r;
		endfunction

		function void note_sample(logic [SAMPLE_BITS_DEF-1:0] s);
			speed_q.push_back(predict_speeds(s));
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_speeds(logic [2*OUT_BITS-1:0] d);
			speeds_t want;
			if (speed_q.size() == 0) begin
				report($sformatf("unexpected beat %h", d));
				return;
			end
			want = speed_q.pop_front();
			if (d[OUT_BITS-1:0] !== want.left)
				report($sformatf("left_speed got %0d want %0d",
					$signed(d[OUT_BITS-1:0]), want.left));
			if (d[2*OUT_BITS-1:OUT_BITS] !== want.right)
				report($sformatf("right_speed got %0d want %0d",
					$signed(d[2*OUT_BITS-1:OUT_BITS]), want.right));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TDATA_BITS-1:0] s_tdata;   // light_sample
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2*OUT_BITS-1:0] m_tdata;   // left_speed, right_speed
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	steer_scoreboard steer_sb;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	pd_line_follow_steering_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left == 0 && hold_reqs != hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = hold_reqs;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			steer_sb.check_speeds(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_BITS'(s);
		do @(posedge clk); while (!s_tready);
		steer_sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (steer_sb.speed_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		steer_sb.write_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_cfg(input logic [DATA_BITS-1:0] sp, kp, kd, thr, bs, mx);
		drain();
		apb_write(REG_SETPOINT, sp);
		apb_write(REG_KP_GAIN, kp);
		apb_write(REG_KD_GAIN, kd);
		apb_write(REG_THRESHOLD, thr);
		apb_write(REG_BASE, bs);
		apb_write(REG_MAX, mx);
	endtask

	function automatic logic [DATA_BITS-1:0] rand_gain();
		case ($urandom_range(7))
			0: return 32'h0000_8000;
			1: return 32'h0000_7FFF;
			2: return $urandom();
			default: return DATA_BITS'(int'($urandom_range(1023)) - 512);
		endcase
	endfunction

	function automatic logic [DATA_BITS-1:0] rand_speed();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'd100;
			2: return DATA_BITS'($urandom_range(127, 101));
			default: return DATA_BITS'($urandom_range(100));
		endcase
	endfunction

	task automatic random_cfg();
		logic [DATA_BITS-1:0] sp;
		logic [DATA_BITS-1:0] thr;
		case ($urandom_range(7))
			0: sp = 32'd0;
			1: sp = 32'd1023;
			2: sp = $urandom();
			default: sp = DATA_BITS'($urandom_range(1023));
		endcase
		case ($urandom_range(7))
			0: thr = 32'd0;
			1: thr = 32'hFFFF;
			2: thr = $urandom();
			default: thr = DATA_BITS'($urandom_range(40000));
		endcase
		apply_cfg(sp, rand_gain(), rand_gain(), thr, rand_speed(), rand_speed());
	endtask

	initial begin
		int n;
		logic [SAMPLE_BITS_DEF-1:0] s;
		steer_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: center, spin both ways, edge of the proportional band
		send_sample(10'd512);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd540);
		send_sample(10'd541);
		send_sample(10'd484);
		send_sample(10'd500);

		// gain extremes with garbage above the field widths
		apply_cfg(32'hFFFF_FC00, 32'hABCD_8000, 32'h0000_7FFF, 32'h1234_FFFF,
			32'hFFFF_FF64, 32'd100);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd0);
		send_sample(10'd1);

		// tiny gains, fractional pd truncation, zero base, widest limit
		apply_cfg(32'd1023, 32'd1, 32'hFFFF_FFFF, 32'hFFFF, 32'd0, 32'd127);
		send_sample(10'd1023);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd512);

		// zero threshold spins on zero pd
		apply_cfg(32'd300, 32'd0, 32'd0, 32'd0, 32'd50, 32'd100);
		send_sample(10'd7);
		send_sample(10'd900);

		// base above limit
		apply_cfg(32'd512, 32'd256, 32'd64, 32'd1000, 32'd100, 32'd40);
		send_sample(10'd515);
		send_sample(10'd1000);
		send_sample(10'd20);

		// zero limit
		apply_cfg(32'd512, 32'd256, 32'd0, 32'd7287, 32'd10, 32'd0);
		send_sample(10'd0);
		send_sample(10'd1023);

		// unmapped registers leave the settings alone
		drain();
		apb_write(IDX_UNMAPPED_LO, $urandom());
		apb_write(IDX_UNMAPPED_HI, $urandom());
		send_sample(10'd512);
		send_sample(10'd530);

		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 62 : 0;
			snk_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 32 : 0;
			for (int k = 0; k < 6; k++) begin
				random_cfg();
				if (mode == 0 && k == 1)
					hold_reqs++;
				for (int i = 0; i < RAND_ITEMS; i++) begin
					if ($urandom_range(1)) begin
						s = SAMPLE_BITS_DEF'($urandom_range(1023));
					end else begin
						n = int'(steer_sb.setpoint) + int'($urandom_range(64)) - 32;
						if (n < 0)
							n = 0;
						if (n > 1023)
							n = 1023;
						s = SAMPLE_BITS_DEF'(n);
					end
					send_sample(s);
				end
			end
		end

		drain();
		if (steer_sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
src/pdlf_pkg.sv
src/pd_line_follow_steering_top.sv
bench/tb_top.sv
